FILE: sv/cbmg_pkg.sv
`timescale 1ns / 1ps

package cbmg_pkg;

    localparam int CELLS_DEF       = 24;
    localparam int LOWER_CELLS_DEF = 14;

    localparam int MV_W       = 16;
    localparam int MASK_W     = 24;
    localparam int LOWER_W    = 14;
    localparam int UPPER_W    = 10;
    localparam int ADDR_W     = 3;
    localparam int PDATA_W    = 32;

    localparam logic [MV_W-1:0] MIN_START     = 16'd9999;
    localparam logic [MV_W-1:0] THRESHOLD_RST = 16'd50;
    localparam logic [MV_W-1:0] FLOOR_RST     = 16'd1000;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_FLOOR     = 1'b1;

    typedef struct packed {
        logic [MV_W-1:0] cell_mv;
        logic            last_cell;
        logic            over_temp;
        logic            link_dropped;
    } t_cell_req;

    typedef struct packed {
        logic [MASK_W-1:0]  balance_mask;
        logic [LOWER_W-1:0] lower_mask;
        logic [UPPER_W-1:0] upper_mask;
        logic               all_balanced;
    } t_mask_rsp;

    typedef struct packed {
        logic [MV_W-1:0] threshold_mv;
        logic [MV_W-1:0] floor_mv;
    } t_cfg;

endpackage

FILE: sv/cell_balance_mask_generator.sv
`timescale 1ns / 1ps
// channel   direction  handshake                          payload
// cell in   in         i_in_valid / o_in_stall            i_in_data  (t_cell_req)
// mask out  out        o_out_valid / i_out_stall          o_out_data (t_mask_rsp)
// config    in         psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// a cell that does not close the segment leaves the block idle for the next cell
// the closing cell stalls the input while the block forms the limit,
// compares each stored cell in turn through a single comparator, and loads the output
// over temperature skips the compares
// a result waiting under stall holds the final step until the output register frees
// synchronous active-low reset clears control state and sets the minimum to MIN_START

module cell_balance_mask_generator
    import cbmg_pkg::*;
#(
    parameter int CELLS       = CELLS_DEF,
    parameter int LOWER_CELLS = LOWER_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_cell_req          i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_mask_rsp          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int IDX_W = $clog2(CELLS);
    localparam logic [31:0] LOWER_SEL = (32'd1 << LOWER_CELLS) - 32'd1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    t_cfg w_cfg;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [MV_W-1:0]  r_min;
    logic [MV_W:0]    r_limit;
    logic [CELLS-1:0] r_mask;
    logic             r_hot;
    logic             r_dropped;
    logic [MV_W-1:0]  r_store [CELLS];
    logic             r_out_valid;
    t_mask_rsp        r_out;

    logic             w_acc;
    logic             w_room;
    logic             w_scan_end;
    logic             w_out_free;
    logic [31:0]      w_ext;
    t_mask_rsp        w_rsp;

    cbmg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_acc      = i_in_valid && (r_state == ST_IDLE);
    assign w_room     = (r_count < CNT_W'(CELLS));
    assign w_scan_end = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_acc && w_room) begin
            r_store[r_count[IDX_W-1:0]] <= i_in_data.cell_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_min   <= MIN_START;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                            if (i_in_data.cell_mv > w_cfg.floor_mv
                                    && i_in_data.cell_mv < r_min) begin
                                r_min <= i_in_data.cell_mv;
                            end
                        end
                        if (i_in_data.last_cell) begin
                            r_state <= ST_LIMIT;
                        end
                    end
                end
                ST_LIMIT: begin
                    r_min <= MIN_START;
                    r_idx <= '0;
                    r_state <= r_hot ? ST_EMIT : ST_SCAN;
                end
                ST_SCAN: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (w_scan_end) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_count <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in_data.last_cell) begin
            r_hot     <= i_in_data.over_temp;
            r_dropped <= i_in_data.link_dropped;
            r_mask    <= '0;
        end
        if (r_state == ST_LIMIT) begin
            r_limit <= {1'b0, r_min} + {1'b0, w_cfg.threshold_mv};
        end
        if (r_state == ST_SCAN) begin
            r_mask[r_idx] <= ({1'b0, r_store[r_idx]} > r_limit);
        end
    end

    assign w_ext = 32'(r_mask);

    always_comb begin
        w_rsp.balance_mask = w_ext[MASK_W-1:0];
        w_rsp.lower_mask   = w_ext[LOWER_W-1:0] & LOWER_SEL[LOWER_W-1:0];
        w_rsp.upper_mask   = 10'(w_ext >> LOWER_CELLS);
        w_rsp.all_balanced = (r_mask == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && w_out_free && !r_dropped) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free && !r_dropped) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sv/cbmg_regs.sv
`timescale 1ns / 1ps

module cbmg_regs
    import cbmg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [MV_W-1:0] r_threshold;
    logic [MV_W-1:0] r_floor;
    logic            w_wr;
    logic            w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_sel  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_floor     <= FLOOR_RST;
        end else if (w_wr) begin
            case (w_sel)
                REG_THRESHOLD: r_threshold <= pwdata[MV_W-1:0];
                REG_FLOOR:     r_floor     <= pwdata[MV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_THRESHOLD: prdata = PDATA_W'(r_threshold);
            REG_FLOOR:     prdata = PDATA_W'(r_floor);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.threshold_mv = r_threshold;
    assign o_cfg.floor_mv     = r_floor;

endmodule

FILE: verif/cell_balance_mask_checker.sv
`timescale 1ns / 1ps

module cell_balance_mask_checker
    import cbmg_pkg::*;
#(
    parameter int CELLS       = CELLS_DEF,
    parameter int LOWER_CELLS = LOWER_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_cell_req          i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_mask_rsp          i_out_data,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_pending,
    output int                 o_fail_count
);

    localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
    localparam logic [ADDR_W-1:0] FLOOR_ADDR     = {REG_FLOOR, 2'b00};

    t_cfg            cfg;
    logic [MV_W-1:0] cell_mem [CELLS];
    logic [MV_W-1:0] weakest_mv;
    int              stored_cells;
    t_mask_rsp       mask_queue [$];
    int              fail_count = 0;

    function automatic void start_segment();
        weakest_mv   = MIN_START;
        stored_cells = 0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void absorb_cell(input t_cell_req req);
        logic [MASK_W-1:0] mask_bits;
        logic [MV_W:0]     limit_mv;
        t_mask_rsp         rsp;
        if (stored_cells < CELLS) begin
            cell_mem[stored_cells] = req.cell_mv;
            stored_cells++;
            if (req.cell_mv > cfg.floor_mv && req.cell_mv < weakest_mv)
                weakest_mv = req.cell_mv;
        end
        if (!req.last_cell)
            return;
        mask_bits = '0;
        limit_mv  = {1'b0, weakest_mv} + {1'b0, cfg.threshold_mv};
        if (!req.over_temp) begin
            for (int i = 0; i < stored_cells; i++) begin
                if ({1'b0, cell_mem[i]} > limit_mv)
                    mask_bits[i] = 1'b1;
            end
        end
        start_segment();
        if (req.link_dropped)
            return;
        rsp.balance_mask = mask_bits;
        rsp.lower_mask   = LOWER_W'(mask_bits & ((MASK_W'(1) << LOWER_CELLS) - 1));
        rsp.upper_mask   = UPPER_W'(mask_bits >> LOWER_CELLS);
        rsp.all_balanced = (mask_bits == '0);
        mask_queue.push_back(rsp);
    endfunction

    function automatic void check_mask(input t_mask_rsp got);
        t_mask_rsp want;
        if (mask_queue.size() == 0) begin
            $display("%0t: unexpected mask result, expected none got %h", $time, got);
            fail_count++;
            return;
        end
        want = mask_queue.pop_front();
        check_field("balance_mask", 32'(want.balance_mask), 32'(got.balance_mask));
        check_field("lower_mask", 32'(want.lower_mask), 32'(got.lower_mask));
        check_field("upper_mask", 32'(want.upper_mask), 32'(got.upper_mask));
        check_field("all_balanced", 32'(want.all_balanced), 32'(got.all_balanced));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.threshold_mv = THRESHOLD_RST;
            cfg.floor_mv     = FLOOR_RST;
            start_segment();
            mask_queue.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == THRESHOLD_ADDR)
                    cfg.threshold_mv = i_pwdata[MV_W-1:0];
                else if (i_paddr == FLOOR_ADDR)
                    cfg.floor_mv = i_pwdata[MV_W-1:0];
            end
            if (i_out_valid && !i_out_stall)
                check_mask(i_out_data);
            if (i_in_valid && !i_in_stall)
                absorb_cell(i_in_data);
        end
        o_pending    <= mask_queue.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: verif/cell_balance_mask_generator_test.sv
`timescale 1ns / 1ps

module cell_balance_mask_generator_test;
    import cbmg_pkg::*;

    localparam int SETTLE_CYCLES = CELLS_DEF + 16;
    localparam int PHASE_ITEMS   = 56;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    t_cell_req          in_data    = '0;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    t_mask_rsp          out_data;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [ADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0] pwdata     = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 pending;
    int                 fail_count;
    int                 send_idle_pct  = 38;
    int                 recv_stall_pct = 81;

    cell_balance_mask_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    cell_balance_mask_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_cell_req make_req(input int mv, input logic last,
                                           input logic hot, input logic dropped);
        t_cell_req req;
        req.cell_mv      = MV_W'(mv);
        req.last_cell    = last;
        req.over_temp    = hot;
        req.link_dropped = dropped;
        return req;
    endfunction

    function automatic logic [MV_W-1:0] pick_mv(input int base);
        case ($urandom_range(9))
            0:       return MV_W'($urandom_range(65535));
            1:       return MV_W'($urandom_range(1100));
            default: return MV_W'(base + $urandom_range(120));
        endcase
    endfunction

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic send_cell(input t_cell_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_data  <= t_cell_req'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [MV_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random_segment(output int n);
        int   len;
        int   base;
        logic hot;
        logic dropped;
        logic last;
        case ($urandom_range(9))
            0, 1, 2:    len = $urandom_range(1, 8);
            3, 4:       len = $urandom_range(9, 19);
            5, 6, 7, 8: len = $urandom_range(20, CELLS_DEF);
            default:    len = $urandom_range(CELLS_DEF + 1, CELLS_DEF + 4);
        endcase
        base    = $urandom_range(2500, 4000);
        hot     = ($urandom_range(9) == 0);
        dropped = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            send_cell(make_req(pick_mv(base), last,
                               last ? hot : ($urandom_range(4) == 0),
                               last ? dropped : ($urandom_range(4) == 0)));
        end
        n = len;
    endtask

    initial begin
        int sent;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no cell above the floor
        send_cell(make_req(0, 1'b1, 1'b0, 1'b0));
        // floor boundary, threshold boundary, flags on inner cells ignored
        send_cell(make_req(65535, 1'b0, 1'b0, 1'b0));
        send_cell(make_req(1000, 1'b0, 1'b1, 1'b1));
        send_cell(make_req(1001, 1'b0, 1'b1, 1'b0));
        send_cell(make_req(1051, 1'b0, 1'b0, 1'b1));
        send_cell(make_req(1052, 1'b1, 1'b0, 1'b0));
        // over temperature
        send_cell(make_req(65535, 1'b0, 1'b0, 1'b0));
        send_cell(make_req(2000, 1'b1, 1'b1, 1'b0));
        // link dropped, with and without over temperature
        send_cell(make_req(3000, 1'b0, 1'b0, 1'b0));
        send_cell(make_req(2000, 1'b1, 1'b0, 1'b1));
        send_cell(make_req(5000, 1'b0, 1'b0, 1'b0));
        send_cell(make_req(6000, 1'b1, 1'b1, 1'b1));
        // segment after a drop starts clean
        send_cell(make_req(5000, 1'b0, 1'b0, 1'b0));
        send_cell(make_req(9999, 1'b1, 1'b0, 1'b0));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2)
                set_idle(81, 38);
            else if (ph == 4)
                set_idle(0, 0);
            if (ph > 0) begin
                wait_results_done();
                repeat (SETTLE_CYCLES) @(posedge clk);
                case (ph)
                    1: begin
                        write_reg(REG_THRESHOLD, 16'd0);
                        write_reg(REG_FLOOR, 16'd0);
                    end
                    2: begin
                        write_reg(REG_THRESHOLD, 16'hFFFF);
                        write_reg(REG_FLOOR, 16'hFFFF);
                    end
                    4: begin
                        write_reg(REG_THRESHOLD, 16'hFFFF);
                        write_reg(REG_FLOOR, 16'd0);
                    end
                    default: begin
                        write_reg(REG_THRESHOLD, MV_W'($urandom_range(300)));
                        write_reg(REG_FLOOR, MV_W'($urandom_range(3500)));
                    end
                endcase
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run_random_segment(n);
                sent += n;
                if ($urandom_range(19) == 0)
                    wait_results_done();
            end
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
